@@ rtl/imheq_pkg.sv @@
// Shared constants and types for the indexed min-heap event queue.
package imheq_pkg;

	localparam int HEAP_CAPACITY_DEF = 1024;
	localparam int NODE_COUNT_DEF    = 1024;
	localparam int KEY_BITS_DEF      = 32;

	localparam int CMD_W    = 1;
	localparam int ID_W     = 10;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 32;

	localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  node_id;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]     root_node;
		logic [KEY_W-1:0]    root_key;
		logic [COUNT_W-1:0]  heap_count;
		logic [COUNT_W-1:0]  node_slot;
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  total_inserted;
	} rsp_t;

endpackage

@@ rtl/imheq_req_if.sv @@
// Valid/ready channel carrying one request into the queue.
interface imheq_req_if;
	logic             valid;
	logic             ready;
	imheq_pkg::req_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/imheq_rsp_if.sv @@
// Valid/ready channel carrying one response out of the queue.
interface imheq_rsp_if;
	logic             valid;
	logic             ready;
	imheq_pkg::rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/imheq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module imheq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/indexed_min_heap_event_queue.sv @@
// Indexed binary min-heap event queue: top level with sequencer and heap memories.
// One request is taken at a time; ready stays low until its response has been
// accepted. After reset a clearing pass writes zero to every entry of the node
// position table, during which no request is taken. An insert writes the new
// entry into the next free slot and climbs level by level; a delete clears
// the root's position, moves the last entry into the root slot and descends
// level by level.
// Every sift step uses the single read port of each heap memory: it reads
// parent/children one at a time through that port, compares with the one key
// comparator, and writes the swapped pair back one slot per cycle.
module indexed_min_heap_event_queue #(
	parameter int HEAP_CAPACITY = imheq_pkg::HEAP_CAPACITY_DEF,
	parameter int NODE_COUNT    = imheq_pkg::NODE_COUNT_DEF,
	parameter int KEY_BITS      = imheq_pkg::KEY_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	imheq_req_if.sink   req,
	imheq_rsp_if.source rsp
);
	localparam int SW = $clog2(HEAP_CAPACITY + 1);      // slot index width
	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int IW = imheq_pkg::ID_W;                // node id width
	localparam int PW = SW;                             // position value width
	localparam int SD = 1 << SW;
	localparam int ND = 1 << NW;
	localparam int CW = SW + 1;                         // count width
	localparam logic [CW-1:0] CAP = CW'(HEAP_CAPACITY);

	typedef enum logic [14:0] {
		S_CLEAR  = 15'b000000000000001,
		S_IDLE   = 15'b000000000000010,
		S_INS    = 15'b000000000000100,
		S_UPRD   = 15'b000000000001000,
		S_UPWT   = 15'b000000000010000,
		S_UPCMP  = 15'b000000000100000,
		S_DELRD  = 15'b000000001000000,
		S_DELWT  = 15'b000000010000000,
		S_DELMV  = 15'b000000100000000,
		S_DNRDL  = 15'b000001000000000,
		S_DNRDR  = 15'b000010000000000,
		S_DNCMPL = 15'b000100000000000,
		S_DNCMPR = 15'b001000000000000,
		S_SWAP   = 15'b010000000000000,
		S_POS    = 15'b100000000000000
	} state_t;

	state_t state_q, ret_q;

	// heap memories
	logic          h_we;
	logic [SW-1:0] h_waddr, h_raddr;
	logic [IW-1:0] h_wnode;
	logic [KEY_BITS-1:0] h_wkey;
	logic [IW-1:0] h_rnode;
	logic [KEY_BITS-1:0] h_rkey;
	// position memory
	logic          p_we;
	logic [NW-1:0] p_waddr, p_raddr;
	logic [PW-1:0] p_wdata, p_rdata;

	imheq_ram #(.WIDTH(IW), .DEPTH(SD)) u_node (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wnode),
		.raddr(h_raddr), .rdata(h_rnode));
	imheq_ram #(.WIDTH(KEY_BITS), .DEPTH(SD)) u_key (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wkey),
		.raddr(h_raddr), .rdata(h_rkey));
	imheq_ram #(.WIDTH(PW), .DEPTH(ND)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata));

	logic [CW-1:0]  count_q;
	logic [31:0]    total_q;
	logic [NW-1:0]  clr_q;
	imheq_pkg::req_t req_q;
	logic [SW-1:0]  pos_q, oth_q;          // current slot and swap partner
	logic [IW-1:0]  cur_node_q, oth_node_q;
	logic [KEY_BITS-1:0] cur_key_q, oth_key_q, rkey_l_q;
	logic [IW-1:0]  rnode_l_q;
	logic [SW-1:0]  best_q;
	logic           has_r_q;
	logic [1:0]     swph_q;                // swap write phase
	logic           out_v_q;
	logic [imheq_pkg::STATUS_W-1:0] status_q;

	function automatic logic [NW-1:0] nidx(input logic [imheq_pkg::ID_W-1:0] id);
		logic [31:0] t;
		t = 32'(id) % NODE_COUNT;
		return NW'(t);
	endfunction

	logic [KEY_BITS-1:0] in_key;
	assign in_key = KEY_BITS'(req.data.key);
	// shared comparator: a < b
	logic [KEY_BITS-1:0] cmp_a, cmp_b;
	logic cmp_lt;
	assign cmp_lt = cmp_a < cmp_b;

	logic [CW-1:0] left_c;
	assign left_c = {pos_q, 1'b0};

	always_comb begin
		h_we = 1'b0; h_waddr = pos_q; h_wnode = cur_node_q; h_wkey = cur_key_q;
		h_raddr = pos_q;
		p_we = 1'b0; p_waddr = nidx(cur_node_q); p_wdata = PW'(pos_q);
		p_raddr = nidx(req_q.node_id);
		cmp_a = cur_key_q; cmp_b = oth_key_q;
		case (state_q)
			S_CLEAR: begin
				p_we = 1'b1; p_waddr = clr_q; p_wdata = '0;
			end
			// root held on the read port while the response waits
			S_IDLE:  h_raddr = SW'(1);
			S_INS: begin
				h_we = 1'b1; p_we = 1'b1;
			end
			S_UPRD:  h_raddr = SW'(pos_q >> 1);
			S_UPWT:  h_raddr = oth_q;
			S_UPCMP: begin cmp_a = cur_key_q; cmp_b = h_rkey; end
			S_DELRD: h_raddr = SW'(1);
			S_DELWT: begin
				// root id in read data: clear its position, fetch last entry
				h_raddr = SW'(count_q + 1'b1);
				p_we = 1'b1; p_waddr = nidx(h_rnode); p_wdata = '0;
			end
			S_DELMV: begin
				h_we = 1'b1; h_waddr = SW'(1); h_wnode = h_rnode; h_wkey = h_rkey;
				p_we = 1'b1; p_waddr = nidx(h_rnode); p_wdata = PW'(1);
			end
			S_DNRDL: h_raddr = SW'(left_c);
			S_DNRDR: h_raddr = SW'(left_c + 1'b1);
			S_DNCMPL: begin
				h_raddr = SW'(left_c + 1'b1);
				cmp_a = rkey_l_q; cmp_b = cur_key_q;
			end
			S_DNCMPR: begin cmp_a = h_rkey; cmp_b = oth_key_q; end
			S_SWAP: begin
				h_we = 1'b1;
				if (swph_q == 2'd0) begin
					h_waddr = oth_q; h_wnode = cur_node_q; h_wkey = cur_key_q;
					p_we = 1'b1; p_waddr = nidx(cur_node_q); p_wdata = PW'(oth_q);
				end else begin
					h_waddr = pos_q; h_wnode = oth_node_q; h_wkey = oth_key_q;
					p_we = 1'b1; p_waddr = nidx(oth_node_q); p_wdata = PW'(pos_q);
				end
			end
			S_POS: h_raddr = SW'(1);
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data.root_node  = (count_q != '0) ? h_rnode : '0;
	assign rsp.data.root_key   = (count_q != '0) ? imheq_pkg::KEY_W'(h_rkey) : '0;
	assign rsp.data.heap_count = imheq_pkg::COUNT_W'(count_q);
	assign rsp.data.node_slot  = imheq_pkg::COUNT_W'(p_rdata);
	assign rsp.data.status     = status_q;
	assign rsp.data.total_inserted = total_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; ret_q <= S_IDLE; clr_q <= '0;
			count_q <= '0; total_q <= '0; out_v_q <= 1'b0; swph_q <= '0;
			status_q <= imheq_pkg::ST_OK;
		end else begin
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NODE_COUNT - 1) state_q <= S_IDLE;
				end
				S_IDLE: if (req.valid && req.ready) begin
					req_q <= req.data;
					status_q <= imheq_pkg::ST_OK;
					if (req.data.cmd == imheq_pkg::CMD_INSERT) begin
						if (count_q >= CAP) begin
							status_q <= imheq_pkg::ST_FULL; state_q <= S_POS;
						end else begin
							count_q <= count_q + 1'b1;
							total_q <= total_q + 1'b1;
							pos_q <= SW'(count_q + 1'b1);
							cur_node_q <= req.data.node_id;
							cur_key_q <= in_key;
							state_q <= S_INS;
						end
					end else if (count_q == '0) begin
						status_q <= imheq_pkg::ST_EMPTY; state_q <= S_POS;
					end else state_q <= S_DELRD;
				end
				S_INS: state_q <= S_UPRD;
				S_UPRD: begin
					if (pos_q <= SW'(1)) state_q <= S_POS;
					else begin oth_q <= SW'(pos_q >> 1); state_q <= S_UPWT; end
				end
				S_UPWT: state_q <= S_UPCMP;
				S_UPCMP: begin
					// parent strictly greater: swap child into parent slot
					if (cmp_lt) begin
						oth_node_q <= h_rnode; oth_key_q <= h_rkey;
						swph_q <= '0; ret_q <= S_UPRD; state_q <= S_SWAP;
					end else state_q <= S_POS;
				end
				S_DELRD: begin count_q <= count_q - 1'b1; state_q <= S_DELWT; end
				S_DELWT: begin
					pos_q <= SW'(1);
					state_q <= (count_q == '0) ? S_POS : S_DELMV;
				end
				S_DELMV: begin
					// last entry now in read data, moved into the root slot
					cur_node_q <= h_rnode; cur_key_q <= h_rkey;
					state_q <= S_DNRDL;
				end
				S_DNRDL: begin
					if (left_c > count_q) state_q <= S_POS;
					else begin
						has_r_q <= (left_c + 1'b1) <= count_q;
						state_q <= S_DNRDR;
					end
				end
				S_DNRDR: begin
					// left child arrives here
					rkey_l_q <= h_rkey; rnode_l_q <= h_rnode;
					state_q <= S_DNCMPL;
				end
				S_DNCMPL: begin
					if (cmp_lt) begin
						best_q <= SW'(left_c); oth_key_q <= rkey_l_q; oth_node_q <= rnode_l_q;
					end else begin
						best_q <= pos_q; oth_key_q <= cur_key_q;
					end
					state_q <= S_DNCMPR;
				end
				S_DNCMPR: begin
					if (has_r_q && cmp_lt) begin
						oth_q <= SW'(left_c + 1'b1); oth_key_q <= h_rkey;
						oth_node_q <= h_rnode;
						swph_q <= '0; ret_q <= S_DNRDL; state_q <= S_SWAP;
					end else if (best_q != pos_q) begin
						oth_q <= best_q; swph_q <= '0; ret_q <= S_DNRDL;
						state_q <= S_SWAP;
					end else state_q <= S_POS;
				end
				S_SWAP: begin
					if (swph_q == 2'd0) swph_q <= 2'd1;
					else begin pos_q <= oth_q; state_q <= ret_q; end
				end
				S_POS: begin
					out_v_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
